FILE: rtl/core/cxs_pkg.sv
package cxs_pkg;

  localparam int STATE_WORDS        = 16;
  localparam int ROW_WORDS          = 4;
  localparam int ROUND_PAIRS        = 10;
  localparam int CTR_WORD           = 12;
  localparam int BLOCKS_PER_RUN_DEF = 4;

  localparam int ROT_A = 16;
  localparam int ROT_B = 12;
  localparam int ROT_C = 8;
  localparam int ROT_D = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_COL,
    ST_DIAG_IN,
    ST_DIAG,
    ST_DIAG_OUT,
    ST_OUT,
    ST_INC
  } cxs_state_t;

  typedef struct packed {
    logic shift_in;
    logic load_work;
    logic qr_en;
    logic qr_second;
    logic diag_in;
    logic diag_out;
    logic rot_out;
    logic inc_ctr;
  } cxs_ctrl_t;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
    rotl32 = (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] bswap32(input logic [31:0] v);
    bswap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

FILE: rtl/core/chacha20_stream_xor.sv
// ChaCha20 stream XOR. Feed BLOCKS_PER_RUN*16 text words, then the 16 initial state words,
// one per start pulse while busy is low. After the last state word the block goes busy and
// runs one half quarter-round per cycle on a single shared unit. Each block is a load,
// 10 double rounds, the output of its 16 words and a counter increment. Each output
// word appears for exactly one cycle with out_valid high, and the receiver cannot stall
// it; out_last marks the final word of a run. State word 12 counts up by one per block.
module chacha20_stream_xor
  import cxs_pkg::*;
#(
  parameter int BLOCKS_PER_RUN = BLOCKS_PER_RUN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_word,
  output logic        out_valid,
  output logic [31:0] out_word,
  output logic        out_last
);

  localparam int TEXT_WORDS = BLOCKS_PER_RUN * STATE_WORDS;
  localparam int RUN_WORDS  = TEXT_WORDS + STATE_WORDS;
  localparam int AW         = $clog2(TEXT_WORDS);
  localparam int CW         = $clog2(RUN_WORDS);
  localparam int BW         = (BLOCKS_PER_RUN > 1) ? $clog2(BLOCKS_PER_RUN) : 1;

  cxs_state_t    state_r, state_nxt;
  logic [CW-1:0] wc_r, wc_nxt;
  logic [BW-1:0] blk_r, blk_nxt;
  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic [3:0]    dr_r, dr_nxt;
  logic [2:0]    step_r, step_nxt;
  logic [3:0]    out_cnt_r, out_cnt_nxt;
  logic          vld_r, vld_nxt;
  logic          last_r, last_nxt;
  logic [31:0]   ks_r, ks_nxt;
  logic [31:0]   ks;
  logic [31:0]   text_q;
  logic          mem_we;
  logic          accept;
  cxs_ctrl_t     ctrl;

  assign accept = start && (state_r == ST_IDLE);

  cxs_state u_state (
    .clk       (clk),
    .ctrl_i    (ctrl),
    .in_word_i (in_word),
    .ks_o      (ks)
  );

  cxs_text_mem #(
    .DEPTH (TEXT_WORDS),
    .AW    (AW)
  ) u_text (
    .clk     (clk),
    .we_i    (mem_we),
    .waddr_i (wc_r[AW-1:0]),
    .wdata_i (in_word),
    .raddr_i (rd_addr_r),
    .rdata_o (text_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      wc_r      <= '0;
      blk_r     <= '0;
      rd_addr_r <= '0;
      dr_r      <= '0;
      step_r    <= '0;
      out_cnt_r <= '0;
      vld_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      wc_r      <= wc_nxt;
      blk_r     <= blk_nxt;
      rd_addr_r <= rd_addr_nxt;
      dr_r      <= dr_nxt;
      step_r    <= step_nxt;
      out_cnt_r <= out_cnt_nxt;
      vld_r     <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
    ks_r   <= ks_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    wc_nxt      = wc_r;
    blk_nxt     = blk_r;
    rd_addr_nxt = rd_addr_r;
    dr_nxt      = dr_r;
    step_nxt    = step_r;
    out_cnt_nxt = out_cnt_r;
    vld_nxt     = 1'b0;
    last_nxt    = 1'b0;
    ks_nxt      = ks_r;
    mem_we      = 1'b0;
    ctrl        = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (wc_r < CW'(TEXT_WORDS)) begin
            mem_we = 1'b1;
          end else begin
            ctrl.shift_in = 1'b1;
          end
          if (wc_r == CW'(RUN_WORDS - 1)) begin
            wc_nxt      = '0;
            blk_nxt     = '0;
            rd_addr_nxt = '0;
            state_nxt   = ST_LOAD;
          end else begin
            wc_nxt = wc_r + CW'(1);
          end
        end
      end
      ST_LOAD: begin
        ctrl.load_work = 1'b1;
        dr_nxt         = '0;
        step_nxt       = '0;
        state_nxt      = ST_COL;
      end
      ST_COL: begin
        ctrl.qr_en     = 1'b1;
        ctrl.qr_second = step_r[0];
        step_nxt       = step_r + 3'd1;
        if (step_r == 3'd7) begin
          state_nxt = ST_DIAG_IN;
        end
      end
      ST_DIAG_IN: begin
        ctrl.diag_in = 1'b1;
        state_nxt    = ST_DIAG;
      end
      ST_DIAG: begin
        ctrl.qr_en     = 1'b1;
        ctrl.qr_second = step_r[0];
        step_nxt       = step_r + 3'd1;
        if (step_r == 3'd7) begin
          state_nxt = ST_DIAG_OUT;
        end
      end
      ST_DIAG_OUT: begin
        ctrl.diag_out = 1'b1;
        if (dr_r == 4'(ROUND_PAIRS - 1)) begin
          out_cnt_nxt = '0;
          state_nxt   = ST_OUT;
        end else begin
          dr_nxt    = dr_r + 4'd1;
          state_nxt = ST_COL;
        end
      end
      ST_OUT: begin
        ctrl.rot_out = 1'b1;
        ks_nxt       = ks;
        vld_nxt      = 1'b1;
        last_nxt     = (rd_addr_r == AW'(TEXT_WORDS - 1));
        rd_addr_nxt  = rd_addr_r + AW'(1);
        out_cnt_nxt  = out_cnt_r + 4'd1;
        if (out_cnt_r == 4'(STATE_WORDS - 1)) begin
          state_nxt = ST_INC;
        end
      end
      ST_INC: begin
        ctrl.inc_ctr = 1'b1;
        if (blk_r == BW'(BLOCKS_PER_RUN - 1)) begin
          blk_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          blk_nxt   = blk_r + BW'(1);
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = vld_r;
  assign out_word  = text_q ^ ks_r;
  assign out_last  = last_r;

`ifndef NO_ASSERTIONS
  a_valid_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == ST_OUT)
    else $error("result strobe without output phase");

  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  a_last_final_block: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (state_r == ST_INC && blk_r == BW'(BLOCKS_PER_RUN - 1)))
    else $error("last flag outside final block");

  a_wc_range: assert property (@(posedge clk) disable iff (!rst_n)
    wc_r <= CW'(RUN_WORDS - 1))
    else $error("word count out of range");
`endif

endmodule

FILE: rtl/core/cxs_qr_half.sv
module cxs_qr_half
  import cxs_pkg::*;
(
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  input  logic [31:0] d_i,
  input  logic        second_i,
  output logic [31:0] a_o,
  output logic [31:0] b_o,
  output logic [31:0] c_o,
  output logic [31:0] d_o
);

  logic [31:0] a1;
  logic [31:0] dx;
  logic [31:0] d1;
  logic [31:0] c1;
  logic [31:0] bx;

  always_comb begin
    a1 = a_i + b_i;
    dx = d_i ^ a1;
    d1 = second_i ? rotl32(dx, ROT_C) : rotl32(dx, ROT_A);
    c1 = c_i + d1;
    bx = b_i ^ c1;
    b_o = second_i ? rotl32(bx, ROT_D) : rotl32(bx, ROT_B);
    a_o = a1;
    c_o = c1;
    d_o = d1;
  end

endmodule

FILE: rtl/core/cxs_state.sv
module cxs_state
  import cxs_pkg::*;
(
  input  logic        clk,
  input  cxs_ctrl_t   ctrl_i,
  input  logic [31:0] in_word_i,
  output logic [31:0] ks_o
);

  logic [31:0] work_r   [STATE_WORDS];
  logic [31:0] work_nxt [STATE_WORDS];
  logic [31:0] init_r   [STATE_WORDS];
  logic [31:0] init_nxt [STATE_WORDS];
  logic [31:0] qa, qb, qc, qd;

  cxs_qr_half u_qr (
    .a_i      (work_r[0]),
    .b_i      (work_r[ROW_WORDS]),
    .c_i      (work_r[2*ROW_WORDS]),
    .d_i      (work_r[3*ROW_WORDS]),
    .second_i (ctrl_i.qr_second),
    .a_o      (qa),
    .b_o      (qb),
    .c_o      (qc),
    .d_o      (qd)
  );

  always_comb begin
    logic [31:0] col [STATE_WORDS];
    col = work_r;
    col[0]           = qa;
    col[ROW_WORDS]   = qb;
    col[2*ROW_WORDS] = qc;
    col[3*ROW_WORDS] = qd;
    work_nxt = work_r;
    init_nxt = init_r;
    if (ctrl_i.shift_in) begin
      for (int j = 0; j < STATE_WORDS - 1; j++) init_nxt[j] = init_r[j+1];
      init_nxt[STATE_WORDS-1] = in_word_i;
    end
    if (ctrl_i.load_work) begin
      work_nxt = init_r;
    end
    if (ctrl_i.qr_en) begin
      if (ctrl_i.qr_second) begin
        for (int r = 0; r < ROW_WORDS; r++)
          for (int j = 0; j < ROW_WORDS; j++)
            work_nxt[r*ROW_WORDS+j] = col[r*ROW_WORDS+((j+1)&3)];
      end else begin
        work_nxt = col;
      end
    end
    if (ctrl_i.diag_in) begin
      for (int r = 0; r < ROW_WORDS; r++)
        for (int j = 0; j < ROW_WORDS; j++)
          work_nxt[r*ROW_WORDS+j] = work_r[r*ROW_WORDS+((j+r)&3)];
    end
    if (ctrl_i.diag_out) begin
      for (int r = 0; r < ROW_WORDS; r++)
        for (int j = 0; j < ROW_WORDS; j++)
          work_nxt[r*ROW_WORDS+j] = work_r[r*ROW_WORDS+((j+4-r)&3)];
    end
    if (ctrl_i.rot_out) begin
      for (int j = 0; j < STATE_WORDS; j++) begin
        work_nxt[j] = work_r[(j+1)&15];
        init_nxt[j] = init_r[(j+1)&15];
      end
    end
    if (ctrl_i.inc_ctr) begin
      init_nxt[CTR_WORD] = init_r[CTR_WORD] + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    init_r <= init_nxt;
  end

  assign ks_o = bswap32(work_r[0] + init_r[0]);

endmodule

FILE: rtl/core/cxs_text_mem.sv
module cxs_text_mem
  import cxs_pkg::*;
#(
  parameter int DEPTH = BLOCKS_PER_RUN_DEF * STATE_WORDS,
  parameter int AW    = $clog2(BLOCKS_PER_RUN_DEF * STATE_WORDS)
) (
  input  logic          clk,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_r <= mem[raddr_i];
  end

  assign rdata_o = rdata_r;

endmodule

FILE: test/tb_chacha20_stream_xor.sv
module tb_chacha20_stream_xor;
  timeunit 1ns;
  timeprecision 1ps;
  import cxs_pkg::*;

  localparam int BLOCKS       = BLOCKS_PER_RUN_DEF;
  localparam int TEXT_WORDS   = BLOCKS * STATE_WORDS;
  localparam int RUN_WORDS    = TEXT_WORDS + STATE_WORDS;
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 250;
  localparam int RAND_RUNS    = 2;
  localparam int DIR_RUNS     = 1;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } xor_word_t;

  typedef struct packed {
    logic [31:0] text_fill;
    logic [31:0] text_step;
    logic [31:0] state_fill;
    logic [31:0] ctr;
  } run_row_t;

  localparam run_row_t DIR_ROWS [DIR_RUNS] = '{
    '{32'hFFFF_FFFF, 32'h1111_1111, 32'hFFFF_FFFF, 32'hFFFF_FFFE}
  };

  localparam int IDLE_PCT [RAND_RUNS] = '{79, 15};

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_word;
  logic        out_valid;
  logic [31:0] out_word;
  logic        out_last;

  logic [31:0] run_buf   [RUN_WORDS];
  logic [31:0] text_copy [TEXT_WORDS];
  logic [31:0] key_state [STATE_WORDS];
  logic [31:0] mix_state [STATE_WORDS];
  int          fill_pos;
  xor_word_t   pending_words [$];
  xor_word_t   want;
  int          fail_count;
  int          quiet_cycles;

  chacha20_stream_xor #(
    .BLOCKS_PER_RUN(BLOCKS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word),
    .out_last (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] rot_left(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] byte_flip(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function void mix_quarter(input int a, input int b, input int c, input int d);
    mix_state[a] = mix_state[a] + mix_state[b];
    mix_state[d] = rot_left(mix_state[d] ^ mix_state[a], ROT_A);
    mix_state[c] = mix_state[c] + mix_state[d];
    mix_state[b] = rot_left(mix_state[b] ^ mix_state[c], ROT_B);
    mix_state[a] = mix_state[a] + mix_state[b];
    mix_state[d] = rot_left(mix_state[d] ^ mix_state[a], ROT_C);
    mix_state[c] = mix_state[c] + mix_state[d];
    mix_state[b] = rot_left(mix_state[b] ^ mix_state[c], ROT_D);
  endfunction

  function void xor_keystream_run();
    int        b;
    int        r;
    int        i;
    int        k;
    xor_word_t res;
    for (b = 0; b < BLOCKS; b++) begin
      for (i = 0; i < STATE_WORDS; i++) mix_state[i] = key_state[i];
      for (r = 0; r < ROUND_PAIRS; r++) begin
        for (i = 0; i < ROW_WORDS; i++) mix_quarter(i, i + 4, i + 8, i + 12);
        for (i = 0; i < ROW_WORDS; i++)
          mix_quarter(i, ((i + 1) % 4) + 4, ((i + 2) % 4) + 8, ((i + 3) % 4) + 12);
      end
      for (i = 0; i < STATE_WORDS; i++) begin
        k = b * STATE_WORDS + i;
        res.word = text_copy[k] ^ byte_flip(mix_state[i] + key_state[i]);
        res.last = (k == TEXT_WORDS - 1);
        pending_words.push_back(res);
      end
      key_state[CTR_WORD] = key_state[CTR_WORD] + 32'd1;
    end
  endfunction

  function void take_word(input logic [31:0] w);
    if (fill_pos < TEXT_WORDS) text_copy[fill_pos] = w;
    else key_state[fill_pos - TEXT_WORDS] = w;
    fill_pos++;
    if (fill_pos == RUN_WORDS) begin
      fill_pos = 0;
      xor_keystream_run();
    end
  endfunction

  function void fill_from_row(input run_row_t row);
    int k;
    for (k = 0; k < TEXT_WORDS; k++) run_buf[k] = row.text_fill + k * row.text_step;
    for (k = 0; k < STATE_WORDS; k++) run_buf[TEXT_WORDS + k] = row.state_fill;
    run_buf[TEXT_WORDS + CTR_WORD] = row.ctr;
  endfunction

  function void fill_random_run();
    int k;
    for (k = 0; k < RUN_WORDS; k++) run_buf[k] = $urandom;
    if ($urandom_range(0, 1) == 1) begin
      run_buf[TEXT_WORDS + 0] = 32'h6170_7865;
      run_buf[TEXT_WORDS + 1] = 32'h3320_646e;
      run_buf[TEXT_WORDS + 2] = 32'h7962_2d32;
      run_buf[TEXT_WORDS + 3] = 32'h6b20_6574;
    end
    if ($urandom_range(0, 2) == 0)
      run_buf[TEXT_WORDS + CTR_WORD] = 32'hFFFF_FFFF - $urandom_range(0, BLOCKS);
  endfunction

  task automatic send_run(input int idle_pct);
    int k;
    k = 0;
    while (k < RUN_WORDS) begin
      @(negedge clk);
      if ($urandom_range(0, 99) < idle_pct) begin
        start   = 1'b0;
        in_word = $urandom;
      end else begin
        start   = 1'b1;
        in_word = run_buf[k];
      end
      @(posedge clk);
      if (start && !busy) k++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) quiet_cycles = 0;
      else quiet_cycles++;
      if (start && !busy) take_word(in_word);
      if (out_valid) begin
        if (pending_words.size() == 0) begin
          if (fail_count < MAX_REPORTS)
            $display("%0t: unexpected result word %h last %b", $realtime, out_word, out_last);
          fail_count++;
        end else begin
          want = pending_words.pop_front();
          if (out_word !== want.word || out_last !== want.last) begin
            if (fail_count < MAX_REPORTS)
              $display("%0t: mismatch word exp %h got %h, last exp %b got %b",
                       $realtime, want.word, out_word, want.last, out_last);
            fail_count++;
          end
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: timeout, %0d results outstanding", $realtime, pending_words.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int r;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_word      = 32'd0;
    fill_pos     = 0;
    fail_count   = 0;
    quiet_cycles = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (r = 0; r < DIR_RUNS; r++) begin
      fill_from_row(DIR_ROWS[r]);
      send_run(0);
    end
    for (r = 0; r < RAND_RUNS; r++) begin
      fill_random_run();
      send_run(IDLE_PCT[r]);
    end
    @(negedge clk);
    start = 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
